FILE: sv/palette_bank_loader_core_defines.svh
// Assertion macros shared by the palette bank loader modules.
`ifndef PALETTE_BANK_LOADER_CORE_DEFINES_SVH
`define PALETTE_BANK_LOADER_CORE_DEFINES_SVH

// Check that ante implies cons in the same cycle (uses clk_i / rst_ni of the module).
`define PLB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("palette bank loader: same-cycle check failed");

// Check that ante implies cons in the following cycle.
`define PLB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("palette bank loader: next-cycle check failed");

`endif

FILE: sv/plb_pkg.sv
// Types, constants and helper functions of the palette bank loader.
package plb_pkg;

  localparam int unsigned PromDepth = 320;
  localparam int unsigned PromAw    = 9;
  localparam int unsigned PairW     = 6;
  localparam int unsigned ColorW    = 15;

  // Load address map
  localparam logic [9:0] WholeEnd   = 10'h040;
  localparam logic [9:0] LowEnd     = 10'h140;
  localparam logic [9:0] HighEnd    = 10'h240;
  localparam logic [9:0] HighOffset = 10'h100;

  // Pair layout
  localparam logic [PairW-1:0] FgFirst     = 6'd8;
  localparam logic [PairW-1:0] SpriteFirst = 6'd24;
  localparam logic [PairW-1:0] TileLast    = 6'd23;
  localparam logic [PairW-1:0] SpriteLast  = 6'd39;

  typedef enum logic {
    StIdle,
    StRun
  } seq_state_e;

  // One pair read issued by the sequencer
  typedef struct packed {
    logic                 valid;
    logic [PairW-1:0]     pair;
    logic                 last;
    logic                 even_zero;
    logic [PromAw-1:0]    addr_even;
    logic [PromAw-1:0]    addr_odd;
  } plb_issue_t;

  // Inverted 3-3-3 color word
  function automatic logic [ColorW-1:0] to_color(input logic [7:0] c);
    logic [ColorW-1:0] r;
    r = '0;
    r[4:2]   = ~c[2:0];
    r[9:7]   = ~c[5:3];
    r[14:12] = ~c[7:5];
    return r;
  endfunction

  // PROM entry of the even color of a pair
  function automatic logic [PromAw-1:0] even_addr(input logic [3:0] bank,
                                                  input logic [PairW-1:0] pair);
    logic [PromAw-1:0] base;
    if (pair < FgFirst) begin
      base = {4'b0, bank[3], 4'b0};
    end else begin
      base = {1'b0, bank[2:0], 5'b0} + 9'd16;
    end
    return base + {2'b0, pair, 1'b0};
  endfunction

  // PROM entry of the odd color of a pair
  function automatic logic [PromAw-1:0] odd_addr(input logic [3:0] bank,
                                                 input logic [PairW-1:0] pair);
    logic [PromAw-1:0] r;
    if (pair >= FgFirst && pair < SpriteFirst) begin
      r = {4'b0, bank[3], 4'b0} + {3'b0, pair} + 9'd24;
    end else begin
      r = even_addr(bank, pair) | 9'd1;
    end
    return r;
  endfunction

endpackage

FILE: sv/palette_bank_loader_core.sv
// Palette bank loader: color PROM image and bank-change pair stream.
//
// Input channel (in_valid_i / in_ready_o): req_type_i = 0 writes one PROM byte
// (whole byte, low nibble or high nibble, by prom_addr_i); it gives no result.
// req_type_i = 1 selects a palette bank; when it differs from the last bank it
// starts a stream of palette pairs.
// Output channel (out_valid_o / out_ready_i): one pair per item, last_o marks
// the final pair of a bank change.
// Throughput: one pair per cycle unless stalled by out_ready_i, set by the
// two-port PROM read issued by the sequencer; a bank change streams 16, 24 or
// 40 pairs, during which in_ready_o is low. An unchanged bank item starts none.
// Stall: a low out_ready_i with a pair pending freezes the output register, the
// read stage and the pair counter, so no pair is lost or repeated.
// Reset: no output pending, bank cleared, and the first bank item after reset
// reloads all 40 pairs. PROM contents are undefined until written.
`include "palette_bank_loader_core_defines.svh"

module palette_bank_loader_core
  import plb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [9:0]        prom_addr_i,
  input  logic [7:0]        prom_byte_i,
  input  logic [3:0]        bank_select_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PairW-1:0]  pair_index_o,
  output logic [ColorW-1:0] color_even_o,
  output logic [ColorW-1:0] color_odd_o,
  output logic              last_o
);

  logic              accept;
  logic              adv;
  plb_issue_t        issue;
  logic              we_lo, we_hi;
  logic [PromAw-1:0] waddr;
  logic [9:0]        hi_addr;
  logic [3:0]        wdata_hi;
  logic [3:0]        lo_even, lo_odd, hi_even, hi_odd;

  logic              rd_vld_q;
  logic [PairW-1:0]  rd_pair_q;
  logic              rd_last_q;
  logic              rd_zero_q;

  logic              out_valid_q;
  logic [PairW-1:0]  out_pair_q;
  logic [ColorW-1:0] out_even_q;
  logic [ColorW-1:0] out_odd_q;
  logic              out_last_q;

  assign accept = in_valid_i && in_ready_o;
  assign adv    = !out_valid_q || out_ready_i;

  plb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && req_type_i),
    .bank_i  (bank_select_i),
    .adv_i   (adv),
    .ready_o (in_ready_o),
    .issue_o (issue)
  );

  // Decode load items into nibble writes
  assign hi_addr = prom_addr_i - HighOffset;
  always_comb begin
    we_lo    = 1'b0;
    we_hi    = 1'b0;
    waddr    = prom_addr_i[PromAw-1:0];
    wdata_hi = prom_byte_i[3:0];
    if (accept && !req_type_i) begin
      if (prom_addr_i < WholeEnd) begin
        we_lo    = 1'b1;
        we_hi    = 1'b1;
        wdata_hi = prom_byte_i[7:4];
      end else if (prom_addr_i < LowEnd) begin
        we_lo = 1'b1;
      end else if (prom_addr_i < HighEnd) begin
        we_hi = 1'b1;
        waddr = hi_addr[PromAw-1:0];
      end
    end
  end

  plb_ram #(.Width(4), .Depth(PromDepth)) u_prom_lo (
    .clk_i     (clk_i),
    .we_i      (we_lo),
    .waddr_i   (waddr),
    .wdata_i   (prom_byte_i[3:0]),
    .re_i      (adv),
    .raddr_a_i (issue.addr_even),
    .raddr_b_i (issue.addr_odd),
    .rdata_a_o (lo_even),
    .rdata_b_o (lo_odd)
  );

  plb_ram #(.Width(4), .Depth(PromDepth)) u_prom_hi (
    .clk_i     (clk_i),
    .we_i      (we_hi),
    .waddr_i   (waddr),
    .wdata_i   (wdata_hi),
    .re_i      (adv),
    .raddr_a_i (issue.addr_even),
    .raddr_b_i (issue.addr_odd),
    .rdata_a_o (hi_even),
    .rdata_b_o (hi_odd)
  );

  // Read stage control, advance with the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      rd_vld_q    <= issue.valid;
      out_valid_q <= rd_vld_q;
    end
  end

  // Read stage tag and output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_pair_q  <= issue.pair;
      rd_last_q  <= issue.last;
      rd_zero_q  <= issue.even_zero;
      out_pair_q <= rd_pair_q;
      out_last_q <= rd_last_q;
      out_even_q <= rd_zero_q ? '0 : to_color({hi_even, lo_even});
      out_odd_q  <= to_color({hi_odd, lo_odd});
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_index_o = out_pair_q;
  assign color_even_o = out_even_q;
  assign color_odd_o  = out_odd_q;
  assign last_o       = out_last_q;

  `PLB_ASSERT_IMP(a_last_pair, out_valid_o && last_o,
                  pair_index_o == TileLast || pair_index_o == SpriteLast)
  `PLB_ASSERT_IMP(a_no_load_while_busy, we_lo || we_hi, in_ready_o)

endmodule

FILE: sv/plb_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module plb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/plb_seq.sv
// Bank tracker and pair sequencer: issues one pair read per cycle while adv_i is high.
`include "palette_bank_loader_core_defines.svh"

module plb_seq
  import plb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [3:0] bank_i,
  input  logic       adv_i,
  output logic       ready_o,
  output plb_issue_t issue_o
);

  seq_state_e       state_q, state_d;
  logic [PairW-1:0] pair_q, pair_d;
  logic [PairW-1:0] end_q, end_d;
  logic [3:0]       bank_q, bank_d;
  logic             known_q, known_d;
  logic [3:0]       diff;
  logic             is_last;

  assign diff    = known_q ? (bank_i ^ bank_q) : 4'hF;
  assign is_last = (pair_q == end_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i && (diff != 4'h0)) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (adv_i && is_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Counter and bank registers
  always_comb begin
    pair_d  = pair_q;
    end_d   = end_q;
    bank_d  = bank_q;
    known_d = known_q;
    case (state_q)
      StIdle: begin
        if (start_i && (diff != 4'h0)) begin
          pair_d  = diff[3] ? '0 : SpriteFirst;
          end_d   = (diff[2:0] != 3'b0) ? SpriteLast : TileLast;
          bank_d  = bank_i;
          known_d = 1'b1;
        end
      end
      StRun: begin
        if (adv_i && !is_last) begin
          pair_d = pair_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    ready_o             = (state_q == StIdle);
    issue_o.valid       = (state_q == StRun) && adv_i;
    issue_o.pair        = pair_q;
    issue_o.last        = is_last;
    issue_o.even_zero   = (pair_q >= FgFirst) && (pair_q < SpriteFirst);
    issue_o.addr_even   = even_addr(bank_q, pair_q);
    issue_o.addr_odd    = odd_addr(bank_q, pair_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pair_q  <= '0;
      end_q   <= TileLast;
      bank_q  <= '0;
      known_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pair_q  <= pair_d;
      end_q   <= end_d;
      bank_q  <= bank_d;
      known_q <= known_d;
    end
  end

  `PLB_ASSERT_IMP(a_pair_range, state_q == StRun, pair_q <= end_q && end_q <= SpriteLast)
  `PLB_ASSERT_NXT(a_last_ends_run, issue_o.valid && issue_o.last, state_q == StIdle)
  `PLB_ASSERT_NXT(a_stall_holds, state_q == StRun && !adv_i, $stable(pair_q))

endmodule
